// ===== hw/rtl/mhpq_pkg.sv =====
// Shared types and constants of the max-priority queue.
package mhpq_pkg;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;

    // Field widths of the command and result words
    localparam int KEY_FIELD_W   = 32;
    localparam int STATUS_W      = 2;
    localparam int HELD_W        = 7;

    // Command codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command word
    typedef struct packed {
        logic                           action;
        logic signed [KEY_FIELD_W-1:0]  key_value;
    } t_cmd;

    // Result word
    typedef struct packed {
        logic signed [KEY_FIELD_W-1:0]  popped_key;
        logic [STATUS_W-1:0]            status;
        logic [HELD_W-1:0]              entries_held;
    } t_result;

    // Per-cycle control broadcast along the row of cells
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/mhpq_cell.sv =====
// One storage cell of the sorted row: holds a key and its valid flag.
module mhpq_cell #(
    parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mhpq_pkg::t_cell_ctl    i_ctl,
    input  logic [KEY_WIDTH-1:0]   i_new_key,
    // neighbour nearer the head (larger keys)
    input  logic [KEY_WIDTH-1:0]   i_up_key,
    input  logic                   i_up_valid,
    input  logic                   i_up_keep,
    // neighbour nearer the tail (smaller keys)
    input  logic [KEY_WIDTH-1:0]   i_dn_key,
    input  logic                   i_dn_valid,
    output logic [KEY_WIDTH-1:0]   o_key,
    output logic                   o_valid,
    output logic                   o_keep
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 r_valid;
    logic                 n_valid;
    logic                 w_keep;

    // Keep own key on push when it is held and not below the new key
    assign w_keep = r_valid && ($signed(r_key) >= $signed(i_new_key));

    // Choose: hold, take new key, take key from above, or take key from below
    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctl.push) begin
            if (w_keep) begin
                n_key   = r_key;
                n_valid = 1'b1;
            end else if (i_up_keep) begin
                n_key   = i_new_key;
                n_valid = 1'b1;
            end else begin
                n_key   = i_up_key;
                n_valid = i_up_valid;
            end
        end else if (i_ctl.pop) begin
            n_key   = i_dn_key;
            n_valid = i_dn_valid;
        end
    end

    // Key needs no reset; valid flag does
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_keep  = w_keep;

endmodule

// ===== hw/rtl/max_heap_priority_queue.sv =====
// Top level of the max-priority queue: command decode, cell row and result word.
//
// Usage: drive i_cmd and raise start; the command word is taken at a rising
// edge with start high and busy low. action selects a push of key_value or a
// pop of the largest key held. Every command yields exactly one result word
// on o_result, shown for one cycle with o_strobe high, in the cycle after the
// command was taken. busy stays low, so a command may be issued in every
// cycle: one command per cycle. The rate is set by a single compare per
// cell against the broadcast key and a one-step move between neighbouring
// cells of the row.
// Keys are kept in a row of CAPACITY cells, sorted largest first, so the
// head cell always holds the maximum. A push drops into place by shifting
// the smaller keys one cell down; a pop takes the head and shifts the row up.
// A pop on an empty queue returns 0 with status empty; a push on a full
// queue is dropped with status full. entries_held gives the count after
// the command. Synchronous active-low reset empties the queue at once by
// clearing every valid flag. The receiver cannot stall: each result word
// must be taken in the cycle it is shown.
module max_heap_priority_queue #(
    parameter int CAPACITY  = mhpq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mhpq_pkg::t_cmd    i_cmd,
    output logic              o_strobe,
    output mhpq_pkg::t_result o_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                 w_accept;
    logic                 w_is_pop;
    logic                 w_full;
    logic                 w_empty;
    mhpq_pkg::t_cell_ctl  w_ctl;
    logic [63:0]          w_key_ext;
    logic [KEY_WIDTH-1:0] w_new_key;
    logic [63:0]          w_head_ext;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_strobe;
    mhpq_pkg::t_result    r_result;
    mhpq_pkg::t_result    n_result;
    logic [63:0]          w_count_ext;

    logic [KEY_WIDTH-1:0] w_key   [CAPACITY];
    logic                 w_valid [CAPACITY];
    logic                 w_keep  [CAPACITY];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_is_pop = (i_cmd.action == mhpq_pkg::ACT_POP);
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // Decode the command into the row control
    assign w_ctl.push = w_accept && !w_is_pop && !w_full;
    assign w_ctl.pop  = w_accept && w_is_pop && !w_empty;

    // Take the low key bits of the zero-extended field
    assign w_key_ext = 64'(unsigned'(i_cmd.key_value));
    assign w_new_key = w_key_ext[KEY_WIDTH-1:0];

    // Build the row of cells, head first
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [KEY_WIDTH-1:0] w_up_key;
            logic                 w_up_valid;
            logic                 w_up_keep;
            logic [KEY_WIDTH-1:0] w_dn_key;
            logic                 w_dn_valid;

            if (g == 0) begin : g_head
                assign w_up_key   = '0;
                assign w_up_valid = 1'b1;
                assign w_up_keep  = 1'b1;
            end else begin : g_mid
                assign w_up_key   = w_key[g-1];
                assign w_up_valid = w_valid[g-1];
                assign w_up_keep  = w_keep[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_dn_key   = '0;
                assign w_dn_valid = 1'b0;
            end else begin : g_body
                assign w_dn_key   = w_key[g+1];
                assign w_dn_valid = w_valid[g+1];
            end

            mhpq_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_new_key  (w_new_key),
                .i_up_key   (w_up_key),
                .i_up_valid (w_up_valid),
                .i_up_keep  (w_up_keep),
                .i_dn_key   (w_dn_key),
                .i_dn_valid (w_dn_valid),
                .o_key      (w_key[g]),
                .o_valid    (w_valid[g]),
                .o_keep     (w_keep[g])
            );
        end
    endgenerate

    // Advance the count
    always_comb begin
        n_count = r_count;
        if (w_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_head_ext  = 64'(w_key[0]);
    assign w_count_ext = 64'(n_count);

    // Form the result word
    always_comb begin
        n_result              = '0;
        n_result.entries_held = w_count_ext[mhpq_pkg::HELD_W-1:0];
        if (w_is_pop) begin
            if (w_empty) begin
                n_result.status = mhpq_pkg::ST_EMPTY;
            end else begin
                n_result.popped_key = w_head_ext[mhpq_pkg::KEY_FIELD_W-1:0];
                n_result.status     = mhpq_pkg::ST_OK;
            end
        end else if (w_full) begin
            n_result.status = mhpq_pkg::ST_FULL;
        end else begin
            n_result.status = mhpq_pkg::ST_OK;
        end
    end

    // Register the count, strobe and result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= w_accept;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Count never passes the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Head cell is occupied exactly when the queue is not empty
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] == (r_count != '0))
        else $error("head valid flag disagrees with count");

    // Each taken command gives one strobe in the next cycle
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_strobe)
        else $error("missing result strobe");

    // An empty pop leaves the queue empty
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_pop && w_empty) |=> (r_count == '0))
        else $error("empty pop changed the count");

    // A push on a full queue keeps the count
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_pop && w_full) |=> (r_count == CNT_W'(CAPACITY)))
        else $error("full push changed the count");

endmodule
